// ===== rtl/wah_lfo_pkg.sv =====
// Shared types and constants for the wah LFO waveform generator.
`default_nettype none

package wah_lfo_pkg;

  // Top of the level range and its derived constants
  localparam int unsigned MAX_LEVEL = 127;
  localparam logic [7:0]  LEVEL_TOP = 8'(MAX_LEVEL);
  localparam logic [7:0]  LEVEL_HALF = 8'(MAX_LEVEL / 2);

  // Configuration port widths
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SPEED      = 8'd0,
    REG_WAVEFORM   = 8'd1,
    REG_LED_SCALER = 8'd2,
    REG_LED_OFFSET = 8'd3
  } cfg_addr_e;

  // Waveform selection codes
  typedef enum logic [1:0] {
    WAVE_RAMP_DOWN = 2'd0,
    WAVE_RAMP_UP   = 2'd1,
    WAVE_PULSE     = 2'd2,
    WAVE_TRI       = 2'd3
  } waveform_e;

  // Current register settings
  typedef struct packed {
    logic [7:0] speed;
    waveform_e  waveform;
    logic [7:0] led_scaler;
    logic [7:0] led_offset;
  } cfg_t;

  // Oscillator stage handed to the PWM mapping stage
  typedef struct packed {
    logic       valid;
    logic [7:0] wah;
  } osc_stage_t;

endpackage

`default_nettype wire

// ===== rtl/wah_lfo_ifs.sv =====
// Channel interfaces: tick input, result output and configuration writes.
`default_nettype none

// Tick input channel
interface wah_lfo_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// Result output channel
interface wah_lfo_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] compare_value;
  logic [7:0]  wah_level;

  modport source (output valid, output compare_value, output wah_level, input ready);
  modport sink   (input valid, input compare_value, input wah_level, output ready);
endinterface

// Configuration write channel
interface wah_lfo_cfg_if;
  import wah_lfo_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/wah_lfo_cfg_regs.sv =====
// Configuration register file for the wah LFO.
`default_nettype none

module wah_lfo_cfg_regs
  import wah_lfo_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  wah_lfo_cfg_if.sink cfg_ch,
  output cfg_t        cfg
);

  // Writes are always taken
  assign cfg_ch.ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed      <= 8'd0;
      cfg.waveform   <= WAVE_RAMP_DOWN;
      cfg.led_scaler <= 8'd1;
      cfg.led_offset <= 8'd0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_SPEED:      cfg.speed      <= cfg_ch.data;
        REG_WAVEFORM:   cfg.waveform   <= waveform_e'(cfg_ch.data[1:0]);
        REG_LED_SCALER: cfg.led_scaler <= cfg_ch.data;
        REG_LED_OFFSET: cfg.led_offset <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wah_lfo_osc.sv =====
// Prescaler and level stepping; registers the applied wah level on each firing.
`default_nettype none

module wah_lfo_osc
  import wah_lfo_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  in_valid,
  input  wire logic  in_tick,
  output logic       in_ready,
  input  wire logic  down_ready,
  output osc_stage_t stage
);

  logic       take;
  logic [7:0] prescale_count;
  logic [7:0] prescale_inc;
  logic       fire;
  logic [7:0] level_count;
  logic [7:0] level_count_next;
  logic       tri_going_down;
  logic       tri_going_down_next;
  logic [7:0] wah_next;
  logic [7:0] saw_level;

  // Stage register frees up when empty or when the next stage takes it
  assign in_ready = !stage.valid || down_ready;
  assign take     = in_valid && in_ready && in_tick;

  // Prescaler fires when it passes the speed threshold
  assign prescale_inc = prescale_count + 8'd1;
  assign fire         = take && (prescale_inc > cfg.speed);

  // Saw step wraps at the top of the level range
  assign saw_level = (level_count >= LEVEL_TOP) ? 8'd0 : level_count + 8'd1;

  // Waveform step
  always_comb begin
    level_count_next    = level_count;
    tri_going_down_next = tri_going_down;
    wah_next            = 8'd0;
    unique case (cfg.waveform)
      WAVE_RAMP_DOWN: begin
        level_count_next = saw_level;
        wah_next         = LEVEL_TOP - saw_level;
      end
      WAVE_RAMP_UP: begin
        level_count_next = saw_level;
        wah_next         = saw_level;
      end
      WAVE_PULSE: begin
        level_count_next = saw_level;
        wah_next         = (saw_level >= LEVEL_HALF) ? LEVEL_TOP : 8'd0;
      end
      WAVE_TRI: begin
        if (tri_going_down) begin
          level_count_next    = (level_count != 8'd0) ? level_count - 8'd1 : level_count;
          tri_going_down_next = (level_count_next != 8'd0);
        end else begin
          level_count_next    = (level_count < LEVEL_TOP) ? level_count + 8'd1 : level_count;
          tri_going_down_next = (level_count_next >= LEVEL_TOP);
        end
        wah_next = level_count_next;
      end
      default: ;
    endcase
  end

  // Oscillator state
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= 8'd0;
      level_count    <= 8'd0;
      tri_going_down <= 1'b0;
    end else if (take) begin
      prescale_count <= fire ? 8'd0 : prescale_inc;
      if (fire) begin
        level_count    <= level_count_next;
        tri_going_down <= tri_going_down_next;
      end
    end
  end

  // Stage register toward the PWM mapping
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_ready) begin
      stage.valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      stage.wah <= wah_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wah_lfo_pwm_map.sv =====
// Maps the wah level to a PWM compare value and holds the result register.
`default_nettype none

module wah_lfo_pwm_map
  import wah_lfo_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire osc_stage_t stage,
  output logic            stage_ready,
  wah_lfo_out_if.source   out_ch
);

  logic [15:0] pwm_top;
  logic [8:0]  pwm_sub;
  logic [15:0] compare_next;

  // Result register loads when empty or when its transaction completes
  assign stage_ready = !out_ch.valid || out_ch.ready;

  // Compare value: scaler * top level - offset - level, floored at zero
  assign pwm_top      = 16'(cfg.led_scaler) * 16'(LEVEL_TOP);
  assign pwm_sub      = {1'b0, cfg.led_offset} + {1'b0, stage.wah};
  assign compare_next = (pwm_top > 16'(pwm_sub)) ? pwm_top - 16'(pwm_sub) : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (stage_ready) begin
      out_ch.valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && stage.valid) begin
      out_ch.compare_value <= compare_next;
      out_ch.wah_level     <= stage.wah;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wah_lfo_waveform_generator.sv =====
// Wah LFO waveform generator: a prescaler and a waveform stepper feeding a PWM mapping.
//
// Each accepted transaction with tick set advances an 8-bit prescaler; when it passes
// the speed register it returns to zero and the level counter steps by the selected
// waveform (saw down, saw up, square, triangle). One result then follows with the
// applied level and the compare value led_scaler*127 - led_offset - level, floored
// at zero. A transaction without tick, or one that does not fire, gives no result.
// One transaction is accepted every cycle while ready is high; a result passes a
// register after the level stepping and another after the multiply and
// subtract. While a result waits, input is still taken until the stage ahead of the
// result register holds a result of its own; then ready stays low until the result
// register is freed. Configuration writes are taken in any cycle; write them
// only while no result is pending. Speed 255 stops the oscillator.
`default_nettype none

module wah_lfo_waveform_generator
  import wah_lfo_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  wah_lfo_in_if.sink    in_ch,
  wah_lfo_out_if.source out_ch,
  wah_lfo_cfg_if.sink   cfg_ch
);

  cfg_t       cfg;
  osc_stage_t stage;
  logic       stage_ready;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  // Configuration registers
  wah_lfo_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Prescaler and waveform stepping
  wah_lfo_osc u_osc (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_ch.valid),
    .in_tick    (in_ch.tick),
    .in_ready   (in_ready),
    .down_ready (stage_ready),
    .stage      (stage)
  );

  // PWM mapping and result register
  wah_lfo_pwm_map u_pwm_map (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stage       (stage),
    .stage_ready (stage_ready),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// ===== dv/wah_lfo_checker.sv =====
// Checker for the wah LFO generator: tracks settings, predicts results and compares them.
module wah_lfo_checker
  import wah_lfo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  wah_lfo_in_if       in_ch,
  wah_lfo_out_if      out_ch,
  wah_lfo_cfg_if      cfg_ch,
  output int unsigned errors,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] compare_value;
    logic [7:0]  wah_level;
  } lfo_result_t;

  // Shadow of the register settings and the oscillator state
  cfg_t        regs;
  logic [7:0]  prescale;
  logic [7:0]  level;
  logic        going_down;
  lfo_result_t expected_results[$];

  // Advance the oscillator by one tick; returns 1 when the prescaler fires
  function automatic bit step_oscillator(output lfo_result_t res);
    int unsigned wah;
    int unsigned pwm_top;
    int unsigned pwm_sub;
    res = '0;
    prescale = prescale + 8'd1;
    if (prescale <= regs.speed) return 1'b0;
    prescale = '0;

    case (regs.waveform)
      WAVE_RAMP_DOWN, WAVE_RAMP_UP, WAVE_PULSE: begin
        // 8-bit increment, then wrap at the top of the level range
        level = 8'(((int'(level) + 1) % 256) % (MAX_LEVEL + 1));
      end
      default: begin
        // triangle: clamp at the ends and turn around there
        if (going_down) begin
          if (level > 8'd0) level = level - 8'd1;
          if (level == 8'd0) going_down = 1'b0;
        end else begin
          if (level < LEVEL_TOP) level = level + 8'd1;
          if (level >= LEVEL_TOP) going_down = 1'b1;
        end
      end
    endcase

    case (regs.waveform)
      WAVE_RAMP_DOWN: wah = (MAX_LEVEL - int'(level)) & 8'hFF;
      WAVE_PULSE:     wah = (level >= LEVEL_HALF) ? MAX_LEVEL : 0;
      default:        wah = level;
    endcase

    // PWM mapping, floored at zero
    pwm_top = int'(regs.led_scaler) * MAX_LEVEL;
    pwm_sub = int'(regs.led_offset) + wah;
    res.compare_value = (pwm_top > pwm_sub) ? 16'(pwm_top - pwm_sub) : 16'd0;
    res.wah_level     = 8'(wah);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    lfo_result_t res;
    lfo_result_t exp_res;
    if (rst) begin
      regs.speed      = 8'd0;
      regs.waveform   = WAVE_RAMP_DOWN;
      regs.led_scaler = 8'd1;
      regs.led_offset = 8'd0;
      prescale        = 8'd0;
      level           = 8'd0;
      going_down      = 1'b0;
      errors          = 0;
      expected_results.delete();
    end else begin
      // Compare each result transaction with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: compare_value %0d wah_level %0d",
                 out_ch.compare_value, out_ch.wah_level);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.compare_value !== exp_res.compare_value) begin
            $error("compare_value expected %0d actual %0d",
                   exp_res.compare_value, out_ch.compare_value);
            errors++;
          end
          if (out_ch.wah_level !== exp_res.wah_level) begin
            $error("wah_level expected %0d actual %0d",
                   exp_res.wah_level, out_ch.wah_level);
            errors++;
          end
        end
      end

      // Register writes; unknown indexes are dropped
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_SPEED:      regs.speed      = cfg_ch.data;
          REG_WAVEFORM:   regs.waveform   = waveform_e'(cfg_ch.data[1:0]);
          REG_LED_SCALER: regs.led_scaler = cfg_ch.data;
          REG_LED_OFFSET: regs.led_offset = cfg_ch.data;
          default: ;
        endcase
      end

      // Tick transactions
      if (in_ch.valid && in_ch.ready && in_ch.tick) begin
        if (step_oscillator(res)) expected_results.push_back(res);
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== dv/wah_lfo_waveform_generator_tb.sv =====
// Testbench top for the wah LFO generator: clock, reset, tick and register stimulus, verdict.
module wah_lfo_waveform_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wah_lfo_pkg::*;

  localparam realtime     CLK_HALF     = 6ns;
  localparam int unsigned RESET_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam realtime     RUN_LIMIT    = 5ms;
  localparam int unsigned TICK_TARGET  = 800;
  localparam int unsigned CALM_TICKS   = 120;
  localparam int unsigned REG_COUNT    = 4;
  // Opening pattern under reset settings, mixed ticks and idle transactions
  localparam logic [19:0] OPENING_TICKS = 20'b1101_1011_1110_0110_1101;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned check_errors;
  int unsigned results_pending;
  int unsigned ticks_sent;
  bit          gaps_on;
  bit          calm;

  wah_lfo_in_if  in_ch();
  wah_lfo_out_if out_ch();
  wah_lfo_cfg_if cfg_ch();

  wah_lfo_waveform_generator u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wah_lfo_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (check_errors),
    .pending (results_pending)
  );

  always #CLK_HALF clk = ~clk;

  // Result side: ready drops in random bursts
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (gaps_on && !calm && $urandom_range(9, 0) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // One tick transaction, with an occasional gap ahead of it
  task automatic send_item(logic tick);
    if (gaps_on && !calm && $urandom_range(5, 0) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick  <= tick;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Ticks with idle transactions sprinkled in
  task automatic run_ticks(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(4, 0) == 0) send_item(1'b0);
      send_item(1'b1);
    end
    ticks_sent += count;
  endtask

  // Hold off until every expected result is back and the pipe has emptied
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_regs(logic [7:0] speed, waveform_e wave,
                              logic [7:0] scaler, logic [7:0] offset);
    write_reg(REG_SPEED, speed);
    write_reg(REG_WAVEFORM, 8'(wave));
    write_reg(REG_LED_SCALER, scaler);
    write_reg(REG_LED_OFFSET, offset);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] speed;
    logic [7:0] scaler;
    in_ch.valid  <= 1'b0;
    in_ch.tick   <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr  <= '0;
    cfg_ch.data  <= '0;
    ticks_sent = 0;
    gaps_on    = 1'b1;
    calm       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: speed 0, saw down
    for (int i = 0; i < $bits(OPENING_TICKS); i++) send_item(OPENING_TICKS[i]);
    wait_drained();

    // Zero scaler: compare value floors at zero
    program_regs(8'd0, WAVE_RAMP_UP, 8'd0, 8'd0);
    run_ticks(20);
    wait_drained();

    // Speed 255: prescaler wraps and never fires
    program_regs(8'd255, WAVE_PULSE, 8'd1, 8'd255);
    run_ticks(270);
    wait_drained();

    // Full triangle sweep at the widest PWM range
    program_regs(8'd0, WAVE_TRI, 8'd255, 8'd255);
    run_ticks(270);
    wait_drained();

    // Unknown register index must be dropped
    write_reg(8'($urandom_range(255, REG_COUNT)), 8'($urandom_range(255, 0)));
    program_regs(8'd1, WAVE_RAMP_DOWN, 8'd2, 8'd200);
    run_ticks(60);
    wait_drained();

    // Random settings, mostly fast so results come often
    while (ticks_sent < TICK_TARGET) begin
      gaps_on = ($urandom_range(3, 0) != 0);
      speed   = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 0))
                                            : 8'($urandom_range(3, 0));
      scaler  = ($urandom_range(9, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
      program_regs(speed, waveform_e'($urandom_range(3, 0)), scaler,
                   8'($urandom_range(255, 0)));
      run_ticks($urandom_range(80, 20));
      wait_drained();
    end

    // Closing stretch at full rate
    calm = 1'b1;
    program_regs(8'd0, waveform_e'($urandom_range(3, 0)), 8'($urandom_range(255, 1)),
                 8'($urandom_range(255, 0)));
    run_ticks(CALM_TICKS);
    wait_drained();

    if (results_pending != 0) $error("%0d expected results never arrived", results_pending);
    if (check_errors == 0 && results_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #RUN_LIMIT;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wah_lfo_pkg.sv
rtl/wah_lfo_ifs.sv
rtl/wah_lfo_cfg_regs.sv
rtl/wah_lfo_osc.sv
rtl/wah_lfo_pwm_map.sv
rtl/wah_lfo_waveform_generator.sv
dv/wah_lfo_checker.sv
dv/wah_lfo_waveform_generator_tb.sv
